// ----- rtl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Word layouts of both channels, configuration register indexes and the
// pattern view handed from the configuration block to the match block.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Pattern storage is fixed at 32 bytes, kept in four 64-bit registers.
    localparam int PAT_BYTES     = 32;
    localparam int PAT_WORDS     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int PLEN_W        = 6;
    localparam int OUT_OFFSET_W  = 32;
    localparam int SEG_NUM_W     = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LO0   = 3'd0,
        CFG_PAT_LO1   = 3'd1,
        CFG_PAT_HI0   = 3'd2,
        CFG_PAT_HI1   = 3'd3,
        CFG_WILDCARD  = 3'd4,
        CFG_PLEN      = 3'd5
    } cfg_reg_e_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
        logic       search_start;
    } in_item_t;

    typedef struct packed {
        logic                    match_now;
        logic [OUT_OFFSET_W-1:0] match_offset;
        logic [SEG_NUM_W-1:0]    match_segment;
        logic                    found_before;
    } out_item_t;

    // Pattern as seen from the window: entry k lines up with the byte that
    // arrived k words ago, and care[k] is set where that byte must compare.
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] aligned;
        logic [PAT_BYTES-1:0]      care;
        logic [PLEN_W-1:0]         plen;
        logic                      plen_ok;
    } pattern_cfg_t;

endpackage

// ----- rtl/wbps_cfg.sv -----
// ----------------------------------------------------------------------------
// wbps_cfg: configuration registers of the pattern scanner
// Holds the pattern, wildcard mask and length, and presents the pattern
// reversed and aligned to the byte window.
// ----------------------------------------------------------------------------
module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output pattern_cfg_t           pat_cfg
);

    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_reg;
    logic [PAT_BYTES-1:0]                 wildcard_reg;
    logic [PLEN_W-1:0]                    plen_reg;
    logic [PAT_BYTES-1:0][7:0]            pat_flat;
    logic [PLEN_W-1:0]                    pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_words_reg <= '0;
            wildcard_reg  <= '0;
            plen_reg      <= PLEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e_t'(cfg_index))
                CFG_PAT_LO0:  pat_words_reg[0] <= cfg_wdata;
                CFG_PAT_LO1:  pat_words_reg[1] <= cfg_wdata;
                CFG_PAT_HI0:  pat_words_reg[2] <= cfg_wdata;
                CFG_PAT_HI1:  pat_words_reg[3] <= cfg_wdata;
                CFG_WILDCARD: wildcard_reg     <= cfg_wdata[PAT_BYTES-1:0];
                CFG_PLEN:     plen_reg         <= cfg_wdata[PLEN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign pat_flat = pat_words_reg;

    // Window entry k holds the byte that pattern byte plen-1-k must match.
    always_comb
    begin
        pos = '0;
        pat_cfg.aligned = '0;
        pat_cfg.care    = '0;
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            pos = plen_reg - PLEN_W'(k) - PLEN_W'(1);
            pat_cfg.aligned[k] = pat_flat[pos[4:0]];
            pat_cfg.care[k]    = (PLEN_W'(k) < plen_reg) && !wildcard_reg[pos[4:0]];
        end
        pat_cfg.plen    = plen_reg;
        pat_cfg.plen_ok = (plen_reg != '0) && (plen_reg <= PLEN_W'(PAT_BYTES))
                          && ({1'b0, plen_reg} <= (PLEN_W + 1)'(PATTERN_MAX));
    end

endmodule

// ----- rtl/wbps_match.sv -----
// ----------------------------------------------------------------------------
// wbps_match: window, segment tracking and match compare
// Shifts one byte into the window per processed word, tracks the segment
// byte count and number, and compares the window against the pattern.
// ----------------------------------------------------------------------------
module wbps_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int OFFSET_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  in_item_t     item,
    input  pattern_cfg_t pat_cfg,
    output out_item_t    result
);

    // Bytes older than the longest pattern are never compared.
    localparam int WIN_DEPTH = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [WIN_DEPTH-1:0][7:0]        window_reg, window_next;
    logic [OFFSET_BITS-1:0]           count_reg, count_next;
    logic [SEG_NUM_W-1:0]             seg_reg, seg_next;
    logic                             found_reg, found_next;
    logic                             seen_reg;

    logic [OFFSET_BITS-1:0]           count_base;
    logic [OFFSET_BITS-1:0]           plen_ext;
    logic [OFFSET_BITS-1:0]           diff;
    logic [OFFSET_BITS+OUT_OFFSET_W-1:0] diff_wide;
    logic [WIN_DEPTH-1:0]             byte_ok;
    logic                             found_cur;
    logic                             hit;

    always_comb
    begin
        found_cur = item.search_start ? 1'b0 : found_reg;

        if (item.search_start)
            seg_next = '0;
        else if (item.segment_start && seen_reg)
            seg_next = seg_reg + SEG_NUM_W'(1);
        else
            seg_next = seg_reg;

        count_base = (item.search_start || item.segment_start) ? '0 : count_reg;
        count_next = (count_base == COUNT_MAX) ? count_base
                                               : count_base + OFFSET_BITS'(1);

        window_next[0] = item.data_byte;
        for (int k = 1; k < WIN_DEPTH; k++)
            window_next[k] = window_reg[k-1];

        for (int k = 0; k < WIN_DEPTH; k++)
            byte_ok[k] = !pat_cfg.care[k] || (window_next[k] == pat_cfg.aligned[k]);

        plen_ext  = OFFSET_BITS'(pat_cfg.plen);
        hit       = !found_cur && pat_cfg.plen_ok && (count_next >= plen_ext) && (&byte_ok);
        diff      = count_next - plen_ext;
        diff_wide = {{OUT_OFFSET_W{1'b0}}, diff};

        found_next = found_cur || hit;

        result.match_now     = hit;
        result.match_offset  = hit ? diff_wide[OUT_OFFSET_W-1:0] : '0;
        result.match_segment = hit ? seg_next : '0;
        result.found_before  = found_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            seg_reg    <= '0;
            found_reg  <= 1'b0;
            seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            seg_reg    <= seg_next;
            found_reg  <= found_next;
            seen_reg   <= 1'b1;
        end
    end

    // A reported match must latch the found flag for the rest of the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.match_now |=> found_reg)
        else $error("found flag not set after a match");

    // Once found, no further match until a new search begins.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && found_reg && !item.search_start |-> !result.match_now)
        else $error("second match reported within one search");

    // A new search restarts segment numbering from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.search_start |=> (seg_reg == '0) && (count_reg == OFFSET_BITS'(1)))
        else $error("search start did not reset segment tracking");

endmodule

// ----- rtl/wildcard_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner: streaming wildcard byte pattern search
// Scans a byte stream for a pattern of up to 32 bytes with per-byte
// wildcards and reports the first match of each search.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Word           Direction
//  -------   ------------------   ------------   ---------
//  input     in_valid / in_stall  in_item        into block
//  output    out_valid/out_stall  out_item       out of block
//  config    cfg_we               cfg_index,     into block
//                                 cfg_wdata
//
// One word is accepted per cycle unless in_stall is raised, and every word
// produces one result word. A word is held in the input register and then
// in the output register; throughput is one word per clock while neither
// channel stalls, set by the combinational window compare in the match stage.
// Reset clears the window, segment tracking, found flag and pattern length
// back to one. A stall on the output holds the result and, once the input
// register is also full, raises in_stall in the same cycle.
//
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,

    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Input register: holds one accepted word until the match stage takes it.
    in_item_t     in_item_reg;
    logic         in_valid_reg, in_valid_next;

    // Output register: holds one result word until the consumer takes it.
    out_item_t    out_item_reg;
    logic         out_valid_reg, out_valid_next;

    pattern_cfg_t pat_cfg;
    out_item_t    match_result;
    logic         fire;
    logic         in_take;

    // The match stage processes the held word whenever the output register
    // is empty or is being emptied in this cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
        if (fire)
            out_item_reg <= match_result;
    end

    wbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pat_cfg   (pat_cfg)
    );

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .item    (in_item_reg),
        .pat_cfg (pat_cfg),
        .result  (match_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A held input word that could not be processed must still be there.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("held input word lost while blocked");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the wildcard byte pattern scanner
// Streams bytes through the scanner under random idle and stall on both
// channels, predicts every result word from a behavioral copy of the
// window, segment tracking and first-match flag, and compares each result
// word field by field in order. Pattern settings change between phases
// while the scanner is idle.
// ----------------------------------------------------------------------------
module tb;
    import wbps_pkg::*;

    localparam int CLK_HALF  = 6;
    // Byte used as the single-byte pattern of the segment number wrap run.
    localparam logic [7:0] WRAP_BYTE = 8'h5A;

    // ------------------------------------------------------------------------
    // Scan tracker: keeps its own copy of the pattern registers and of the
    // scanner state, works out the result word of every accepted byte and
    // holds those words until the scanner delivers them.
    // ------------------------------------------------------------------------
    class scan_tracker;
        logic [63:0]          pat_words [PAT_WORDS];
        logic [31:0]          wild;
        logic [PLEN_W-1:0]    plen;
        logic [7:0]           recent [PAT_BYTES];
        longint unsigned      seg_count;
        logic [SEG_NUM_W-1:0] seg_num;
        bit                   found;
        bit                   seen_any;
        out_item_t            results_due [$];
        int                   errors;

        function new();
            foreach (pat_words[k]) pat_words[k] = '0;
            foreach (recent[k]) recent[k] = '0;
            wild      = '0;
            plen      = PLEN_W'(1);
            seg_count = 0;
            seg_num   = '0;
            found     = 1'b0;
            seen_any  = 1'b0;
            errors    = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 20)
                $display("%0t: %s", $time, what);
        endtask

        function logic [7:0] pattern_byte(int j);
            return pat_words[j / 8][(j % 8) * 8 +: 8];
        endfunction

        function void set_register(cfg_reg_e_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PAT_LO0:  pat_words[0] = value;
                CFG_PAT_LO1:  pat_words[1] = value;
                CFG_PAT_HI0:  pat_words[2] = value;
                CFG_PAT_HI1:  pat_words[3] = value;
                CFG_WILDCARD: wild = value[31:0];
                CFG_PLEN:     plen = value[PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Pattern byte j lines up with the byte that arrived n-1-j words ago.
        function bit window_hit(int n);
            int j;
            for (j = 0; j < n; j++)
                if (!wild[j] && recent[n - 1 - j] != pattern_byte(j))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void take_byte(in_item_t w);
            out_item_t r;
            int        k;
            int        n;
            n = int'(plen);
            if (w.search_start) begin
                found     = 1'b0;
                seg_num   = '0;
                seg_count = 0;
            end
            else if (w.segment_start) begin
                if (seen_any)
                    seg_num = seg_num + 1'b1;
                seg_count = 0;
            end
            seen_any = 1'b1;
            for (k = PAT_BYTES - 1; k > 0; k--)
                recent[k] = recent[k - 1];
            recent[0] = w.data_byte;
            if (seg_count < 64'hFFFF_FFFF)
                seg_count++;
            r = '0;
            r.found_before = found;
            if (!found && n >= 1 && n <= PAT_BYTES &&
                seg_count >= longint'(n) && window_hit(n)) begin
                found           = 1'b1;
                r.match_now     = 1'b1;
                r.match_offset  = OUT_OFFSET_W'(seg_count - longint'(n));
                r.match_segment = seg_num;
            end
            results_due = {results_due, r};
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = results_due.pop_front();
            if (got.match_now !== want.match_now)
                report_mismatch($sformatf("match_now %b, expected %b",
                                          got.match_now, want.match_now));
            if (got.match_offset !== want.match_offset)
                report_mismatch($sformatf("match_offset %0d, expected %0d",
                                          got.match_offset, want.match_offset));
            if (got.match_segment !== want.match_segment)
                report_mismatch($sformatf("match_segment %0d, expected %0d",
                                          got.match_segment, want.match_segment));
            if (got.found_before !== want.found_before)
                report_mismatch($sformatf("found_before %b, expected %b",
                                          got.found_before, want.found_before));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the scanner. Every input has a known value from time
    // zero so that nothing in the scanner starts from X.
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PAT_LO0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    scan_tracker sb = new();

    // Sender and receiver pacing state.
    bit tx_steady     = 1'b0;
    bit pressure_req  = 1'b0;
    bit pressure_done = 1'b0;
    int rx_left       = 0;
    int roll;
    int words_sent    = 0;

    always #CLK_HALF clk = ~clk;

    wildcard_byte_pattern_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Sender side. Inputs change on the falling edge; a word counts as taken
    // at the rising edge where valid is high and the scanner does not stall.
    // A run of steady words keeps valid high and only swaps the payload.
    // ------------------------------------------------------------------------
    function automatic in_item_t make_word(logic [7:0] b, bit seg, bit srch);
        in_item_t w;
        w.data_byte     = b;
        w.segment_start = seg;
        w.search_start  = srch;
        return w;
    endfunction

    // Mostly back to back, sometimes a short pause and now and then a long one.
    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_word(in_item_t w);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= w;
        do @(posedge clk); while (in_stall);
        sb.take_byte(w);
        words_sent++;
    endtask

    // Stops offering words and waits until every predicted result word has
    // come back, then lets the two-stage pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Writes all six registers. The narrow registers get random upper bits,
    // which the scanner must ignore.
    task automatic load_setting(logic [PAT_WORDS-1:0][63:0] words, logic [31:0] mask,
                                logic [PLEN_W-1:0] len);
        write_reg(CFG_PAT_LO0, words[0]);
        write_reg(CFG_PAT_LO1, words[1]);
        write_reg(CFG_PAT_HI0, words[2]);
        write_reg(CFG_PAT_HI1, words[3]);
        write_reg(CFG_WILDCARD, {$urandom, mask});
        write_reg(CFG_PLEN, {$urandom, 26'($urandom), len});
    endtask

    // A well-formed search: one to three segments, each holding a copy of the
    // pattern with random bytes at the wildcard places. Some copies carry one
    // corrupted byte and some segments end before the pattern is complete, so
    // only the head of the pattern is sent in them.
    task automatic send_search_run();
        in_item_t   seq [$];
        int         n;
        int         nseg;
        int         s;
        int         j;
        int         pre;
        int         kind;
        int         cut;
        logic [7:0] b;
        n = int'(sb.plen);
        if (n < 1 || n > PAT_BYTES)
            n = $urandom_range(1, 8);
        tx_steady = ($urandom_range(0, 3) == 0);
        nseg = $urandom_range(1, 3);
        for (s = 0; s < nseg; s++)
        begin
            seq.delete();
            kind = $urandom_range(0, 9);
            pre = (kind >= 8) ? 0 : $urandom_range(0, 5);
            repeat (pre) seq = {seq, make_word(8'($urandom), 1'b0, 1'b0)};
            cut = (kind >= 8 && n > 1) ? $urandom_range(1, n - 1) : n;
            for (j = 0; j < cut; j++)
            begin
                b = sb.wild[j] ? 8'($urandom) : sb.pattern_byte(j);
                seq = {seq, make_word(b, 1'b0, 1'b0)};
            end
            if (kind == 7)
            begin
                j = $urandom_range(pre, seq.size() - 1);
                seq[j].data_byte = seq[j].data_byte ^ 8'($urandom_range(1, 255));
            end
            if (kind < 8)
                repeat ($urandom_range(0, 3))
                    seq = {seq, make_word(8'($urandom), 1'b0, 1'b0)};
            seq[0].segment_start = (s > 0) || ($urandom_range(0, 1) == 1);
            seq[0].search_start  = (s == 0) && ($urandom_range(0, 9) != 0);
            foreach (seq[k])
                send_word(seq[k]);
        end
    endtask

    // Unstructured bytes with scattered segment and search starts.
    task automatic send_noise();
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(3, 12))
            send_word(make_word(8'($urandom), $urandom_range(0, 7) == 0,
                                $urandom_range(0, 15) == 0));
    endtask

    // One search over more than 256 one-byte segments, so the segment number
    // wraps before the single matching byte arrives at the very end.
    task automatic send_wrap_run();
        int         nseg;
        int         k;
        logic [7:0] b;
        tx_steady = 1'b0;
        nseg = $urandom_range(256, 270);
        for (k = 0; k < nseg; k++)
        begin
            b = 8'($urandom);
            if (b == WRAP_BYTE)
                b = b ^ 8'h01;
            send_word(make_word(b, k > 0, k == 0));
        end
        send_word(make_word(WRAP_BYTE, 1'b1, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. The stall line alternates between stretches of stall and
    // stretches of flow with random lengths. Once asked, it holds off for a
    // long stretch so that the pipeline fills up and the input stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (pressure_req && !pressure_done)
        begin
            pressure_done = 1'b1;
            out_stall <= 1'b1;
            rx_left = 80;
        end
        else if (rx_left > 0)
        begin
            rx_left--;
        end
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            roll = $urandom_range(0, 99);
            rx_left = (roll < 80) ? $urandom_range(0, 8) : $urandom_range(20, 60);
        end
        else
        begin
            out_stall <= 1'b1;
            roll = $urandom_range(0, 99);
            rx_left = (roll < 75) ? $urandom_range(0, 2) :
                      (roll < 95) ? $urandom_range(3, 9) : $urandom_range(14, 29);
        end
    end

    // Every result word taken by the receiver is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int                          phase;
        int                          phase_start;
        int                          random_from;
        logic [PAT_WORDS-1:0][63:0]  words;
        logic [31:0]                 mask;
        logic [PLEN_W-1:0]           len;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With the reset setting (one pattern byte, zero, no wildcard) the
        // very first byte matches. Whether it opens a segment is left to
        // chance: either way it belongs to segment 0.
        send_word(make_word(8'h00, $urandom_range(0, 1) == 1, 1'b0));
        send_word(make_word(8'h00, 1'b1, 1'b0));
        // Both start flags at once: the search start wins.
        send_word(make_word(8'hFF, 1'b1, 1'b1));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        wait_idle();

        // Four bytes DE AD ?? EF with the third one a wildcard; the unused
        // pattern words hold all-ones, all-zeros and A5 bytes.
        load_setting({64'hA5A5_A5A5_A5A5_A5A5, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h0000_0000_EFBE_ADDE}, 32'h0000_0004, PLEN_W'(4));
        send_word(make_word(8'hDE, 1'b0, 1'b1));
        send_word(make_word(8'hAD, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'hEF, 1'b0, 1'b0));
        // A new search whose first segment is too short: the window does
        // hold the whole pattern once EF arrives, but EF opens a new segment.
        send_word(make_word(8'hDE, 1'b0, 1'b1));
        send_word(make_word(8'hAD, 1'b0, 1'b0));
        send_word(make_word(8'h33, 1'b0, 1'b0));
        send_word(make_word(8'hEF, 1'b1, 1'b0));
        send_word(make_word(8'h11, 1'b0, 1'b0));
        send_word(make_word(8'hDE, 1'b0, 1'b0));
        send_word(make_word(8'hAD, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'hEF, 1'b0, 1'b0));
        // A second copy in the same search is not reported again.
        send_word(make_word(8'hDE, 1'b1, 1'b0));
        send_word(make_word(8'hAD, 1'b0, 1'b0));
        send_word(make_word(8'hBE, 1'b0, 1'b0));
        send_word(make_word(8'hEF, 1'b0, 1'b0));

        // Random phases. The first ones force the extreme settings: longest
        // pattern, single byte, all wildcard, segment number wrap, length
        // zero, lengths beyond the window, all-ones and all-zeros pattern
        // bytes. After that every setting is random.
        random_from = words_sent;
        phase = 0;
        while (words_sent - random_from < 650)
        begin
            wait_idle();
            words = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            mask = $urandom & $urandom & $urandom;
            len = PLEN_W'($urandom_range(2, 12));
            if ($urandom_range(0, 3) == 0)
                len = PLEN_W'($urandom_range(13, 31));
            case (phase)
                0: begin len = PLEN_W'(32); mask = '0; end
                1: begin len = PLEN_W'(1); mask = '0; words[0][7:0] = 8'hFF; end
                2: begin len = PLEN_W'(32); mask = '1; end
                3: begin len = PLEN_W'(1); mask = '0; words[0][7:0] = WRAP_BYTE; end
                4: len = '0;
                5: len = PLEN_W'($urandom_range(33, 63));
                6: begin words = '1; mask = '0; end
                7: words = '0;
                default: ;
            endcase
            load_setting(words, mask, len);
            // The long receiver hold-off lands in the single-byte phase, where
            // the sender keeps offering words throughout.
            if (phase == 1)
                pressure_req = 1'b1;
            if (phase == 3)
            begin
                send_wrap_run();
            end
            else
            begin
                phase_start = words_sent;
                while (words_sent - phase_start < 50)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_noise();
                    else
                        send_search_run();
                end
            end
            phase++;
        end
        wait_idle();
        repeat (8) @(posedge clk);

        if (sb.results_due.size() != 0)
            sb.report_mismatch($sformatf("%0d result words never arrived",
                                         sb.results_due.size()));
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Backstop in case the scanner stops delivering result words.
    initial
    begin
        #(2 * CLK_HALF * 400000);
        $display("tb failed");
        $finish;
    end

endmodule
